[hw/rtl/tsst_pkg.sv]
// Shared types and constants for the TCP session state tracker.
package tsst_pkg;

  localparam int SESSIONS = 1024;
  localparam int ADDR_W   = $clog2(SESSIONS);
  localparam int FLAG_W   = 9;

  // TCP header flag bits
  localparam logic [7:0] TF_FIN  = 8'h01;
  localparam logic [7:0] TF_SYN  = 8'h02;
  localparam logic [7:0] TF_RST  = 8'h04;
  localparam logic [7:0] TF_ACK  = 8'h10;
  localparam logic [7:0] TF_MASK = TF_FIN | TF_SYN | TF_RST | TF_ACK;

  // tracking flag bits
  localparam logic [FLAG_W-1:0] SF_WAIT_RESP_SYN     = 9'h001;
  localparam logic [FLAG_W-1:0] SF_WAIT_INIT_ACK_SYN = 9'h002;
  localparam logic [FLAG_W-1:0] SF_WAIT_RESP_ACK_SYN = 9'h004;
  localparam logic [FLAG_W-1:0] SF_FIN_INIT          = 9'h008;
  localparam logic [FLAG_W-1:0] SF_FIN_RESP          = 9'h010;
  localparam logic [FLAG_W-1:0] SF_ACK_FIN_INIT      = 9'h020;
  localparam logic [FLAG_W-1:0] SF_ACK_FIN_RESP      = 9'h040;
  localparam logic [FLAG_W-1:0] SF_ESTABLISHED       = 9'h080;
  localparam logic [FLAG_W-1:0] SF_TIME_WAIT         = 9'h100;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMBRYONIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESTABLISHED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECURITY    = 2'd2;

  localparam logic [15:0] RST_EMBRYONIC   = 16'd5;
  localparam logic [15:0] RST_ESTABLISHED = 16'd120;
  localparam logic [15:0] RST_SECURITY    = 16'd30;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [9:0]  session_index;
    logic        direction;
    logic [7:0]  tcp_flags;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] current_version;
  } pkt_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [15:0]       version;
    logic [31:0]       fin_forward;
    logic [31:0]       fin_reverse;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [FLAG_W-1:0] old_flags;
    logic [FLAG_W-1:0] new_flags;
    logic              close_session;
    logic              block_session;
    logic              became_established;
    logic [15:0]       timeout_value;
  } result_t;

  typedef struct packed {
    logic [15:0] embryonic;
    logic [15:0] established;
    logic [15:0] security;
  } timeouts_t;

endpackage

[hw/rtl/tsst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tsst_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/tsst_update.sv]
// Per-packet read-modify-write rules: version check, handshake and teardown.
module tsst_update (
  input  tsst_pkg::pkt_t      pkt,
  input  tsst_pkg::entry_t    ent,
  input  tsst_pkg::timeouts_t tmo,
  output tsst_pkg::entry_t    ent_next,
  output logic                ent_we,
  output tsst_pkg::result_t   res
);

  logic [7:0]                  fl;
  logic                        f_syn, f_ack, f_fin, f_rst;
  logic                        mismatch, block;
  tsst_pkg::entry_t            base;
  logic [tsst_pkg::FLAG_W-1:0] sf, nsf;
  logic                        remove, estab;
  logic [15:0]                 tmo_sel;

  assign fl    = pkt.tcp_flags & tsst_pkg::TF_MASK;
  assign f_syn = (fl & tsst_pkg::TF_SYN) != 8'h00;
  assign f_ack = (fl & tsst_pkg::TF_ACK) != 8'h00;
  assign f_fin = (fl & tsst_pkg::TF_FIN) != 8'h00;
  assign f_rst = (fl & tsst_pkg::TF_RST) != 8'h00;

  assign mismatch = ent.version != pkt.current_version;
  // reused slot: only a bare SYN may restart it
  assign block    = mismatch && (fl != tsst_pkg::TF_SYN);

  always_comb begin
    base = ent;
    if (mismatch) begin
      base         = '0;
      base.version = pkt.current_version;
    end
    sf       = base.flags;
    nsf      = sf;
    remove   = 1'b0;
    estab    = 1'b0;
    ent_next = base;

    if (!pkt.direction) begin
      if (f_syn) begin
        if (sf == '0) begin
          nsf = tsst_pkg::SF_WAIT_RESP_SYN | tsst_pkg::SF_WAIT_RESP_ACK_SYN;
        end else begin
          remove = 1'b1;
        end
      end
      if (!remove) begin
        if (f_ack) begin
          if ((sf & tsst_pkg::SF_WAIT_INIT_ACK_SYN) != '0) begin
            nsf = nsf & ~tsst_pkg::SF_WAIT_INIT_ACK_SYN;
          end
          if (((sf & tsst_pkg::SF_FIN_RESP) != '0) &&
              (pkt.ack_num == base.fin_reverse)) begin
            nsf = nsf | tsst_pkg::SF_ACK_FIN_INIT;
          end
        end
        if (f_fin) begin
          nsf                  = (nsf & ~tsst_pkg::SF_ESTABLISHED) | tsst_pkg::SF_FIN_INIT;
          ent_next.fin_forward = pkt.seq_num + 32'd1;
        end
        if (f_rst) begin
          remove = 1'b1;
        end
      end
    end else begin
      if (f_syn && ((sf & tsst_pkg::SF_WAIT_RESP_SYN) != '0)) begin
        nsf = nsf ^ (tsst_pkg::SF_WAIT_RESP_SYN | tsst_pkg::SF_WAIT_INIT_ACK_SYN);
      end
      if (f_ack) begin
        if ((sf & tsst_pkg::SF_WAIT_RESP_ACK_SYN) != '0) begin
          nsf = nsf & ~tsst_pkg::SF_WAIT_RESP_ACK_SYN;
        end
        if (((sf & tsst_pkg::SF_FIN_INIT) != '0) &&
            (pkt.ack_num == base.fin_forward)) begin
          nsf = nsf | tsst_pkg::SF_ACK_FIN_RESP;
        end
      end
      if (f_fin) begin
        nsf                  = (nsf & ~tsst_pkg::SF_ESTABLISHED) | tsst_pkg::SF_FIN_RESP;
        ent_next.fin_reverse = pkt.seq_num + 32'd1;
      end
      if (f_rst) begin
        remove = 1'b1;
      end
    end

    if (!remove) begin
      if (nsf == '0) begin
        nsf   = tsst_pkg::SF_ESTABLISHED;
        estab = 1'b1;
      end
      if (((nsf & tsst_pkg::SF_ACK_FIN_INIT) != '0) &&
          ((nsf & tsst_pkg::SF_ACK_FIN_RESP) != '0)) begin
        nsf    = tsst_pkg::SF_TIME_WAIT;
        remove = 1'b1;
      end
    end
    ent_next.flags = nsf;

    if (remove) begin
      tmo_sel = 16'd0;
    end else if ((nsf & tsst_pkg::SF_ESTABLISHED) != '0) begin
      tmo_sel = tmo.established;
    end else begin
      tmo_sel = tmo.embryonic;
    end

    if (block) begin
      ent_we                 = 1'b0;
      res.old_flags          = ent.flags;
      res.new_flags          = ent.flags;
      res.close_session      = 1'b0;
      res.block_session      = 1'b1;
      res.became_established = 1'b0;
      res.timeout_value      = tmo.security;
    end else begin
      ent_we                 = 1'b1;
      res.old_flags          = sf;
      res.new_flags          = nsf;
      res.close_session      = remove;
      res.block_session      = 1'b0;
      res.became_established = estab;
      res.timeout_value      = tmo_sel;
    end
  end

endmodule

[hw/rtl/tcp_session_state_tracker_top.sv]
// Top level of the TCP session state tracker: session table, sequencer, I/O.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-----------------------------------
//  s_*      | in  | s_tvalid / s_tready        | s_tdata packet fields, s_tuser dir
//  m_*      | out | m_tvalid / m_tready        | m_tdata result fields
//  cfg_*    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data (16-bit timeouts)
//
// Each packet passes through two states: in ST_IDLE its session entry is read
// from the table RAM (registered read data), in ST_WORK the rules are applied
// and the entry is written back unless blocked. A new packet is taken only
// after the last one is done; a packet never overlaps another's read-modify-write.
// After reset a clearing pass zeroes all SESSIONS entries, one per cycle,
// with s_tready low; cfg transfers are taken throughout.
// A stalled m_* side holds the result register; one more packet is accepted
// and then waits in the update cycle until the result register frees up.
module tcp_session_state_tracker_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // packet in: [9:0] session_index, [17:10] tcp_flags, [49:18] seq_num,
  //            [81:50] ack_num, [97:82] current_version, [103:98] zero
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [tsst_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [0] direction
  input  logic                                 s_tuser,
  // result out: [8:0] old_flags, [17:9] new_flags, [18] close_session,
  //             [19] block_session, [20] became_established,
  //             [36:21] timeout_value, [39:37] zero
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tsst_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                          cfg_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WORK  = 2'd2;

  logic [1:0]                  state;
  logic [tsst_pkg::ADDR_W-1:0] clr_addr;
  tsst_pkg::timeouts_t         tmo;
  tsst_pkg::pkt_t              pkt;
  tsst_pkg::result_t           out_res;
  logic                        out_valid;

  tsst_pkg::pkt_t              in_pkt;
  tsst_pkg::entry_t            rd_ent;
  tsst_pkg::entry_t            ent_next;
  tsst_pkg::result_t           upd_res;
  logic                        upd_we;
  logic                        s_xfer, work_done;

  logic                        ram_we;
  logic [tsst_pkg::ADDR_W-1:0] ram_waddr;
  logic [tsst_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  // unpack the packet transfer
  assign in_pkt.session_index   = s_tdata[9:0];
  assign in_pkt.direction       = s_tuser;
  assign in_pkt.tcp_flags       = s_tdata[17:10];
  assign in_pkt.seq_num         = s_tdata[49:18];
  assign in_pkt.ack_num         = s_tdata[81:50];
  assign in_pkt.current_version = s_tdata[97:82];

  assign s_tready  = (state == ST_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  // write-back happens once the result register is free or being drained
  assign work_done = (state == ST_WORK) && (!out_valid || m_tready);

  assign cfg_ready = 1'b1;

  // config registers; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      tmo.embryonic   <= tsst_pkg::RST_EMBRYONIC;
      tmo.established <= tsst_pkg::RST_ESTABLISHED;
      tmo.security    <= tsst_pkg::RST_SECURITY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsst_pkg::CFG_EMBRYONIC:   tmo.embryonic   <= cfg_data;
        tsst_pkg::CFG_ESTABLISHED: tmo.established <= cfg_data;
        tsst_pkg::CFG_SECURITY:    tmo.security    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: clear pass, then read / update per packet
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + tsst_pkg::ADDR_W'(1);
          if (clr_addr == tsst_pkg::ADDR_W'(tsst_pkg::SESSIONS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_xfer) begin
            state <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (work_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // held packet for the update cycle
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      pkt <= in_pkt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (work_done) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work_done) begin
      out_res <= upd_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.timeout_value, out_res.became_established,
                     out_res.block_session, out_res.close_session,
                     out_res.new_flags, out_res.old_flags};

  // table write port: zeros during the clear pass, else the updated entry
  assign ram_we    = (state == ST_CLEAR) || (work_done && upd_we);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr
                                         : pkt.session_index[tsst_pkg::ADDR_W-1:0];
  assign ram_wdata = (state == ST_CLEAR) ? '0 : ent_next;
  assign rd_ent    = ram_rdata;

  tsst_ram #(
    .DEPTH(tsst_pkg::SESSIONS),
    .WIDTH(tsst_pkg::ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s_xfer),
    .raddr (in_pkt.session_index[tsst_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  tsst_update u_update (
    .pkt      (pkt),
    .ent      (rd_ent),
    .tmo      (tmo),
    .ent_next (ent_next),
    .ent_we   (upd_we),
    .res      (upd_res)
  );

endmodule

[hw/rtl/tsst_checker.sv]
// Port-level checks for the TCP session state tracker, bound to the top level.
module tsst_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [tsst_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int REMOVE_BIT = 18;
  localparam int BLOCK_BIT  = 19;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // clear pass keeps the packet side closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("packet accepted during table clear");

  a_remove_xor_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[REMOVE_BIT] && m_tdata[BLOCK_BIT]))
    else $error("remove and block both set");

  a_block_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[BLOCK_BIT] |-> (m_tdata[8:0] == m_tdata[17:9]))
    else $error("blocked packet changed flags");

  a_remove_tmo: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[REMOVE_BIT] |-> (m_tdata[36:21] == 16'd0))
    else $error("removal with nonzero timeout");

endmodule

bind tcp_session_state_tracker_top tsst_checker u_tsst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
